// ----- hw/rtl/urxifb_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// UART receive frame buffer package
// Shared opcodes, field widths and the sequencer state type.
// ---------------------------------------------------------------------------
package urxifb_pkg;

   localparam int OPCODE_W   = 2;
   localparam int BYTE_W     = 8;
   localparam int TICK_W     = 32;
   localparam int READ_MAX_W = 7;

   localparam logic [OPCODE_W-1:0] OP_RX_BYTE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_TICK    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ    = 2'd2;

   localparam logic [TICK_W-1:0] IDLE_LIMIT_RESET = 32'd10;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_READ  = 3'b010,
      ST_EMPTY = 3'b100
   } state_type;

endpackage

// ----- hw/rtl/urxifb_store.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// UART receive frame buffer byte store
// Single write port, single read port, registered read data.
// ---------------------------------------------------------------------------
module urxifb_store #(
   parameter int BUFFER_DEPTH = 64,
   parameter int AW = 6
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [AW-1:0]                   wr_addr,
   input  logic [urxifb_pkg::BYTE_W-1:0]   wr_data,
   input  logic                            rd_en,
   input  logic [AW-1:0]                   rd_addr,
   output logic [urxifb_pkg::BYTE_W-1:0]   rd_data
);
   import urxifb_pkg::*;

   logic [BYTE_W-1:0] store_ff [BUFFER_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/uart_rx_idle_frame_buffer_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// UART receive frame buffer with idle-line detection
// Request channel carries received bytes, timer ticks and read requests.
// Byte and tick words are accepted back to back, also while a response
// word waits on a stalled response channel.
// A read word holds req_stall high until its burst is done, with one store
// read per cycle through the registered memory port while responses flow;
// each byte is staged in the store's read register, then the response one.
// An empty read (flag clear, nothing pending or read_max zero) emits one
// word with has_data 0 and last_of_run 1 from the empty state.
// A stalled response word holds; the burst pauses with it, and the next
// store read waits until the staged byte has moved on.
// csr_wr_en writes idle_limit; write it only while the block is idle.
// Reset clears pointers, flag, last tick and sets idle_limit to 10;
// store contents are left as they are and need no clearing pass.
// ---------------------------------------------------------------------------
module uart_rx_idle_frame_buffer_top #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [urxifb_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [urxifb_pkg::BYTE_W-1:0]      req_rx_byte,
   input  logic [urxifb_pkg::TICK_W-1:0]      req_tick_now,
   input  logic [urxifb_pkg::READ_MAX_W-1:0]  req_read_max,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [urxifb_pkg::BYTE_W-1:0]      rsp_data_byte,
   output logic                               rsp_has_data,
   output logic                               rsp_last_of_run,
   input  logic                               csr_wr_en,
   input  logic [urxifb_pkg::TICK_W-1:0]      csr_wr_data
);
   import urxifb_pkg::*;

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int IW = $clog2(BUFFER_DEPTH + 1);
   localparam logic [IW-1:0] FULL_IDX = IW'(BUFFER_DEPTH);

   state_type              state_ff, state_in;
   logic [IW-1:0]          wr_idx_ff, wr_idx_in;
   logic [IW-1:0]          rd_idx_ff, rd_idx_in;
   logic [TICK_W-1:0]      last_tick_ff, last_tick_in;
   logic                   done_ff, done_in;
   logic [TICK_W-1:0]      idle_limit_ff;
   logic [AW-1:0]          burst_addr_ff, burst_addr_in;
   logic [READ_MAX_W-1:0]  burst_left_ff, burst_left_in;
   logic                   mem_vld_ff, mem_vld_in;
   logic                   mem_last_ff, mem_last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                   rsp_has_ff, rsp_has_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   req_accept;
   logic                   out_load;
   logic                   wr_en;
   logic                   rd_en;
   logic [BYTE_W-1:0]      rd_data;
   logic [TICK_W-1:0]      elapsed;
   logic [READ_MAX_W-1:0]  pending;
   logic [READ_MAX_W-1:0]  count;
   logic [READ_MAX_W-1:0]  rd_sum;

   urxifb_store #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .AW           (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx_ff[AW-1:0]),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (burst_addr_ff),
      .rd_data (rd_data)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_load   = !rsp_valid_ff || !rsp_stall;
   assign wr_en      = req_accept && (req_opcode == OP_RX_BYTE) && (wr_idx_ff != FULL_IDX);
   assign rd_en      = (state_ff == ST_READ) && (burst_left_ff != '0)
                       && (!mem_vld_ff || out_load);
   assign elapsed    = req_tick_now - last_tick_ff;
   assign pending    = (wr_idx_ff > rd_idx_ff) ? READ_MAX_W'(wr_idx_ff - rd_idx_ff) : '0;
   assign count      = (pending < req_read_max) ? pending : req_read_max;
   assign rd_sum     = READ_MAX_W'(rd_idx_ff) + count;

   always_comb begin
      state_in      = state_ff;
      wr_idx_in     = wr_idx_ff;
      rd_idx_in     = rd_idx_ff;
      last_tick_in  = last_tick_ff;
      done_in       = done_ff;
      burst_addr_in = burst_addr_ff;
      burst_left_in = burst_left_ff;
      mem_vld_in    = mem_vld_ff;
      mem_last_in   = mem_last_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_last_in   = rsp_last_ff;

      if (out_load) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_opcode)
                  OP_RX_BYTE: begin
                     if (wr_en) begin
                        wr_idx_in = wr_idx_ff + IW'(1);
                     end
                     done_in      = 1'b0;
                     last_tick_in = req_tick_now;
                  end
                  OP_TICK: begin
                     if (elapsed > idle_limit_ff) begin
                        done_in = 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (!done_ff || count == '0) begin
                        state_in = ST_EMPTY;
                     end else begin
                        state_in      = ST_READ;
                        burst_addr_in = rd_idx_ff[AW-1:0];
                        burst_left_in = count;
                     end
                     if (done_ff) begin
                        done_in = 1'b0;
                        if (rd_sum >= READ_MAX_W'(wr_idx_ff)) begin
                           rd_idx_in = '0;
                           wr_idx_in = '0;
                        end else begin
                           rd_idx_in = IW'(rd_sum);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            if (out_load && mem_vld_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_data;
               rsp_has_in   = 1'b1;
               rsp_last_in  = mem_last_ff;
               mem_vld_in   = 1'b0;
               if (mem_last_ff) begin
                  state_in = ST_IDLE;
               end
            end
            if (rd_en) begin
               mem_vld_in    = 1'b1;
               mem_last_in   = (burst_left_ff == READ_MAX_W'(1));
               burst_left_in = burst_left_ff - READ_MAX_W'(1);
               burst_addr_in = burst_addr_ff + AW'(1);
            end
         end
         ST_EMPTY: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_has_in   = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wr_idx_ff     <= '0;
         rd_idx_ff     <= '0;
         last_tick_ff  <= '0;
         done_ff       <= 1'b0;
         idle_limit_ff <= IDLE_LIMIT_RESET;
         burst_left_ff <= '0;
         mem_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_idx_ff     <= wr_idx_in;
         rd_idx_ff     <= rd_idx_in;
         last_tick_ff  <= last_tick_in;
         done_ff       <= done_in;
         burst_left_ff <= burst_left_in;
         mem_vld_ff    <= mem_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            idle_limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      burst_addr_ff <= burst_addr_in;
      mem_last_ff   <= mem_last_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_byte   = rsp_data_ff;
   assign rsp_has_data    = rsp_has_ff;
   assign rsp_last_of_run = rsp_last_ff;

   a_rd_le_wr: assert property (@(posedge clock) disable iff (reset)
      rd_idx_ff <= wr_idx_ff)
      else $error("read index passed write index");

   a_wr_bound: assert property (@(posedge clock) disable iff (reset)
      wr_idx_ff <= FULL_IDX)
      else $error("write index beyond store depth");

   a_mem_in_burst: assert property (@(posedge clock) disable iff (reset)
      mem_vld_ff |-> (state_ff == ST_READ))
      else $error("staged store data outside a read burst");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_has_ff) |-> rsp_last_ff)
      else $error("empty response word not marked last");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// UART receive frame buffer testbench
// Drives received bytes, timer ticks and read requests through the request
// channel and tracks the buffer, pointers, idle flag and idle limit in a
// local model. Every response word is checked field by field against the
// oldest owed word. Directed tests cover empty reads, idle detection, tick
// wraparound, a full store and the idle limit extremes; random traffic then
// runs under three stall and idle mixes.
// ---------------------------------------------------------------------------
module tb_top;
   import urxifb_pkg::*;

   localparam int DEPTH         = 64;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [OPCODE_W-1:0] OP_IGNORED = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              has_data;
      logic              last;
   } rsp_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OPCODE_W-1:0]   req_opcode = '0;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic [TICK_W-1:0]     req_tick_now = '0;
   logic [READ_MAX_W-1:0] req_read_max = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [BYTE_W-1:0]     rsp_data_byte;
   logic                  rsp_has_data;
   logic                  rsp_last_of_run;
   logic                  csr_wr_en = 1'b0;
   logic [TICK_W-1:0]     csr_wr_data = '0;

   // buffer model
   logic [BYTE_W-1:0] held_bytes [DEPTH];
   int                wr_ptr = 0;
   int                rd_ptr = 0;
   logic [TICK_W-1:0] last_rx_tick = '0;
   logic              frame_done = 1'b0;
   logic [TICK_W-1:0] idle_limit = IDLE_LIMIT_RESET;
   rsp_word_type      owed_words [$];
   rsp_word_type      head_word;

   int          gap_pct = 0;
   int          stall_pct = 0;
   int          mismatches = 0;
   int          cycle_count = 0;
   int          words_sent = 0;
   int          ignored_words = 0;
   int          dropped_bytes = 0;
   int          frames_ended = 0;
   int          data_words = 0;
   int          empty_words = 0;
   logic [31:0] tick_clock = '0;

   uart_rx_idle_frame_buffer_top #(
      .BUFFER_DEPTH(DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_rx_byte    (req_rx_byte),
      .req_tick_now   (req_tick_now),
      .req_read_max   (req_read_max),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_has_data   (rsp_has_data),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still owed", cycle_count,
                  owed_words.size());
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("t=%0t mismatch on %s: got %0h, expected %0h", $time, field, got, want);
      mismatches++;
   endtask

   function automatic void owe_word(input logic [BYTE_W-1:0] data, input logic has_data,
                                    input logic last);
      owed_words.push_back('{data: data, has_data: has_data, last: last});
      if (has_data)
         data_words++;
      else
         empty_words++;
   endfunction

   function automatic void advance_buffer(input logic [OPCODE_W-1:0] op,
                                          input logic [BYTE_W-1:0] rx,
                                          input logic [TICK_W-1:0] now,
                                          input logic [READ_MAX_W-1:0] rmax);
      int          pending;
      int          count;
      logic [31:0] elapsed;
      case (op)
         OP_RX_BYTE: begin
            if (wr_ptr < DEPTH) begin
               held_bytes[wr_ptr] = rx;
               wr_ptr++;
            end else begin
               dropped_bytes++;
            end
            frame_done = 1'b0;
            last_rx_tick = now;
         end
         OP_TICK: begin
            elapsed = now - last_rx_tick;
            if (!frame_done && elapsed > idle_limit) begin
               frame_done = 1'b1;
               frames_ended++;
            end
         end
         OP_READ: begin
            if (!frame_done) begin
               owe_word('0, 1'b0, 1'b1);
            end else begin
               frame_done = 1'b0;
               pending = (wr_ptr > rd_ptr) ? wr_ptr - rd_ptr : 0;
               count = (pending < int'(rmax)) ? pending : int'(rmax);
               for (int i = 0; i < count; i++)
                  owe_word(held_bytes[rd_ptr + i], 1'b1, i == count - 1);
               rd_ptr += count;
               if (rd_ptr >= wr_ptr) begin
                  rd_ptr = 0;
                  wr_ptr = 0;
               end
               if (count == 0)
                  owe_word('0, 1'b0, 1'b1);
            end
         end
         default: begin
         end
      endcase
      if (op == OP_IGNORED)
         ignored_words++;
      else
         words_sent++;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_words.size() == 0) begin
            report_mismatch("unexpected word, data_byte", 32'(rsp_data_byte), 0);
         end else begin
            head_word = owed_words.pop_front();
            if (rsp_data_byte !== head_word.data)
               report_mismatch("data_byte", 32'(rsp_data_byte), 32'(head_word.data));
            if (rsp_has_data !== head_word.has_data)
               report_mismatch("has_data", 32'(rsp_has_data), 32'(head_word.has_data));
            if (rsp_last_of_run !== head_word.last)
               report_mismatch("last_of_run", 32'(rsp_last_of_run), 32'(head_word.last));
         end
      end
   end

   task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] rx,
                            input logic [TICK_W-1:0] now,
                            input logic [READ_MAX_W-1:0] rmax);
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_rx_byte  <= rx;
      req_tick_now <= now;
      req_read_max <= rmax;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_buffer(op, rx, now, rmax);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (owed_words.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_idle_limit(input logic [TICK_W-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      idle_limit = value;
   endtask

   task automatic test_empty_reads();
      send_word(OP_READ, 8'h00, 32'd0, 7'd5);
      send_word(OP_READ, 8'hFF, 32'hFFFF_FFFF, 7'd0);
      send_word(OP_IGNORED, 8'hAA, 32'd1000, 7'd64);
      send_word(OP_READ, 8'h55, 32'd0, 7'd127);
   endtask

   task automatic test_idle_detection();
      send_word(OP_RX_BYTE, 8'h00, 32'd100, 7'd0);
      send_word(OP_RX_BYTE, 8'hFF, 32'd101, 7'd0);
      send_word(OP_RX_BYTE, 8'h5A, 32'd102, 7'd0);
      send_word(OP_TICK, 8'h00, 32'd112, 7'd0);
      send_word(OP_TICK, 8'h00, 32'd113, 7'd0);
      send_word(OP_TICK, 8'h00, 32'd200, 7'd0);
      send_word(OP_READ, 8'h00, 32'd0, 7'd0);
      send_word(OP_READ, 8'h00, 32'd0, 7'd3);
      send_word(OP_TICK, 8'h00, 32'd113, 7'd0);
      send_word(OP_READ, 8'h00, 32'd0, 7'd1);
      send_word(OP_TICK, 8'h00, 32'd113, 7'd0);
      send_word(OP_READ, 8'h00, 32'd0, 7'd127);
      send_word(OP_TICK, 8'h00, 32'd113, 7'd0);
      send_word(OP_READ, 8'h00, 32'd0, 7'd64);
      send_word(OP_RX_BYTE, 8'hA5, 32'hFFFF_FFF8, 7'd0);
      send_word(OP_TICK, 8'h00, 32'h0000_0002, 7'd0);
      send_word(OP_TICK, 8'h00, 32'h0000_0003, 7'd0);
      send_word(OP_READ, 8'h00, 32'd0, 7'd64);
   endtask

   task automatic test_store_full();
      for (int i = 0; i < DEPTH + 2; i++)
         send_word(OP_RX_BYTE, BYTE_W'($urandom_range(255)), 32'd1000 + i, 7'd0);
      send_word(OP_TICK, 8'h00, 32'd1100, 7'd0);
      send_word(OP_READ, 8'h00, 32'd0, 7'd40);
      // hold the sender until the burst is fully out
      wait_drain();
      send_word(OP_TICK, 8'h00, 32'd1100, 7'd0);
      send_word(OP_READ, 8'h00, 32'd0, 7'd127);
   endtask

   task automatic test_limit_extremes();
      write_idle_limit(32'd0);
      send_word(OP_RX_BYTE, 8'h3C, 32'd500, 7'd0);
      send_word(OP_TICK, 8'h00, 32'd500, 7'd0);
      send_word(OP_TICK, 8'h00, 32'd501, 7'd0);
      send_word(OP_READ, 8'h00, 32'd0, 7'd2);
      write_idle_limit(32'hFFFF_FFFF);
      send_word(OP_RX_BYTE, 8'hC3, 32'd7, 7'd0);
      send_word(OP_TICK, 8'h00, 32'd6, 7'd0);
      send_word(OP_READ, 8'h00, 32'd0, 7'd8);
      write_idle_limit(IDLE_LIMIT_RESET);
      send_word(OP_TICK, 8'h00, 32'd18, 7'd0);
      send_word(OP_READ, 8'h00, 32'd0, 7'd8);
   endtask

   task automatic test_random_traffic(input int target, input int send_pct,
                                      input int hold_pct, input logic [31:0] limit,
                                      input logic [31:0] tick_start);
      int                    start_count;
      int                    nbytes;
      int                    nreads;
      logic [31:0]           end_tick;
      logic [31:0]           quiet_span;
      logic [READ_MAX_W-1:0] rmax;
      write_idle_limit(limit);
      gap_pct = send_pct;
      stall_pct = hold_pct;
      tick_clock = tick_start;
      quiet_span = (limit > 32'd1000) ? 32'd1000 : limit;
      start_count = words_sent;
      while (words_sent - start_count < target) begin
         if ($urandom_range(99) < 70) begin
            nbytes = ($urandom_range(19) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
            for (int i = 0; i < nbytes; i++) begin
               tick_clock += $urandom_range(3);
               send_word(OP_RX_BYTE, BYTE_W'($urandom_range(255)), tick_clock,
                         READ_MAX_W'($urandom_range(127)));
               if ($urandom_range(4) == 0)
                  send_word(OP_TICK, BYTE_W'($urandom_range(255)),
                            tick_clock + $urandom_range(quiet_span),
                            READ_MAX_W'($urandom_range(127)));
            end
            end_tick = tick_clock + limit + 1 + $urandom_range(3);
            nreads = $urandom_range(1, 3);
            for (int r = 0; r < nreads; r++) begin
               rmax = READ_MAX_W'(($urandom_range(9) == 0) ? $urandom_range(127)
                                                            : $urandom_range(1, 16));
               send_word(OP_TICK, BYTE_W'($urandom_range(255)), end_tick,
                         READ_MAX_W'($urandom_range(127)));
               send_word(OP_READ, BYTE_W'($urandom_range(255)), $urandom(), rmax);
               if ($urandom_range(15) == 0)
                  wait_drain();
            end
            tick_clock = end_tick;
         end else begin
            send_word(OPCODE_W'($urandom_range(3)), BYTE_W'($urandom_range(255)),
                      $urandom(), READ_MAX_W'($urandom_range(127)));
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      gap_pct = 36;
      stall_pct = 53;
      test_empty_reads();
      test_idle_detection();
      test_store_full();
      test_limit_extremes();
      test_random_traffic(88, 36, 53, IDLE_LIMIT_RESET, $urandom());
      test_random_traffic(88, 53, 36, 32'd0, 32'hFFFF_FF00);
      test_random_traffic(88, 0, 0, $urandom_range(1, 1000), $urandom());
      settle();
      $display("covered %0d request words (%0d ignored), %0d frames ended by idle ticks,",
               words_sent, ignored_words, frames_ended);
      $display("%0d bytes dropped on a full store, %0d data words, %0d empty read words",
               dropped_bytes, data_words, empty_words);
      if (mismatches == 0 && owed_words.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/urxifb_pkg.sv
hw/rtl/urxifb_store.sv
hw/rtl/uart_rx_idle_frame_buffer_top.sv
tb/sv/tb_top.sv
